/* rtl/ubsd_pkg.sv */
// ----------------------------------------------------------------------------
// ubsd_pkg
// Shared types and constants for the UTF-8 byte stream decoder.
// ----------------------------------------------------------------------------
package ubsd_pkg;

	localparam int CP_W       = 21;
	localparam int BYTE_W     = 8;
	localparam int TRAIL_W    = 2;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;
	localparam int LEVEL_W    = 3;

	typedef enum logic [1:0] {
		ST_COMPLETE  = 2'd0,
		ST_TRUNCATED = 2'd1,
		ST_INVALID   = 2'd2,
		ST_END       = 2'd3
	} status_t;

	typedef struct packed {
		logic [CP_W-1:0] code_point;
		status_t         status;
		logic            last;
	} result_t;

	// Results one byte hands to the output queue (count 0..2)
	typedef struct packed {
		logic [1:0] n;
		result_t    res0;
		result_t    res1;
	} push_t;

	typedef struct packed {
		push_t              push;
		logic [CP_W-1:0]    next_partial;
		logic [TRAIL_W-1:0] next_trail;
	} decode_t;

endpackage

/* rtl/ubsd_byte_if.sv */
// ----------------------------------------------------------------------------
// ubsd_byte_if
// Valid/ready channel carrying one raw text byte per transfer.
// ----------------------------------------------------------------------------
interface ubsd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;

	modport source (output valid, output text_byte, input ready);
	modport sink   (input valid, input text_byte, output ready);
endinterface

/* rtl/ubsd_result_if.sv */
// ----------------------------------------------------------------------------
// ubsd_result_if
// Valid/ready channel carrying one decoded result per transfer.
// ----------------------------------------------------------------------------
interface ubsd_result_if;
	logic        valid;
	logic        ready;
	logic [20:0] code_point;
	logic [1:0]  status;
	logic        last;

	modport source (output valid, output code_point, output status, output last,
		input ready);
	modport sink   (input valid, input code_point, input status, input last,
		output ready);
endinterface

/* rtl/ubsd_decode.sv */
// ----------------------------------------------------------------------------
// ubsd_decode
// One decode step: byte plus open-sequence state to results and next state.
// ----------------------------------------------------------------------------
module ubsd_decode (
	input  logic [7:0]           text_byte,
	input  logic [20:0]          partial,
	input  logic [1:0]           trail,
	output ubsd_pkg::decode_t    dec
);
	import ubsd_pkg::*;

	logic            lead_has_res;
	result_t         lead_res;
	logic [CP_W-1:0] lead_partial;
	logic [1:0]      lead_trail;
	logic [CP_W-1:0] shifted;
	logic [1:0]      trail_dec;

	// Byte taken as a lead byte with no sequence open
	always_comb begin
		lead_has_res = 1'b1;
		lead_res     = '{code_point: '0, status: ST_INVALID, last: 1'b1};
		lead_partial = '0;
		lead_trail   = '0;
		if (text_byte == 8'h00) begin
			lead_res.status = ST_END;
		end else if (text_byte inside {[8'h01:8'h7F]}) begin
			lead_res.code_point = {13'd0, text_byte};
			lead_res.status     = ST_COMPLETE;
		end else if (text_byte[7:5] == 3'b110) begin
			lead_has_res = 1'b0;
			lead_partial = {16'd0, text_byte[4:0]};
			lead_trail   = 2'd1;
		end else if (text_byte[7:4] == 4'b1110) begin
			lead_has_res = 1'b0;
			lead_partial = {17'd0, text_byte[3:0]};
			lead_trail   = 2'd2;
		end else if (text_byte[7:3] == 5'b11110) begin
			lead_has_res = 1'b0;
			lead_partial = {18'd0, text_byte[2:0]};
			lead_trail   = 2'd3;
		end
	end

	assign shifted   = {partial[14:0], text_byte[5:0]};
	assign trail_dec = trail - 2'd1;

	always_comb begin
		dec = '0;
		dec.push.res1 = lead_res;
		if (trail != 2'd0 && text_byte[7:6] == 2'b10) begin
			// trail byte extends the open sequence
			dec.next_trail = trail_dec;
			if (trail_dec == 2'd0) begin
				dec.push.n    = 2'd1;
				dec.push.res0 = '{code_point: shifted, status: ST_COMPLETE, last: 1'b1};
			end else begin
				dec.next_partial = shifted;
			end
		end else if (trail != 2'd0) begin
			// sequence cut short; byte reprocessed as lead
			dec.push.res0   = '{code_point: partial, status: ST_TRUNCATED,
				last: ~lead_has_res};
			dec.push.n      = lead_has_res ? 2'd2 : 2'd1;
			dec.next_partial = lead_partial;
			dec.next_trail   = lead_trail;
		end else begin
			dec.push.res0    = lead_res;
			dec.push.n       = lead_has_res ? 2'd1 : 2'd0;
			dec.next_partial = lead_partial;
			dec.next_trail   = lead_trail;
		end
	end

endmodule

/* rtl/ubsd_result_fifo.sv */
// ----------------------------------------------------------------------------
// ubsd_result_fifo
// Four-entry result queue, up to two pushes and one pop per cycle.
// ----------------------------------------------------------------------------
module ubsd_result_fifo (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ubsd_pkg::push_t            push,
	output logic [ubsd_pkg::LEVEL_W-1:0] level,
	ubsd_result_if.source              result
);
	import ubsd_pkg::*;

	result_t              mem [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_q;
	logic [FIFO_AW-1:0]   rd_q;
	logic [LEVEL_W-1:0]   count_q;
	logic                 pop;
	result_t              head;

	assign pop = result.valid & result.ready;

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem[wr_q] <= push.res0;
		end
		if (push.n == 2'd2) begin
			mem[wr_q + FIFO_AW'(1)] <= push.res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + FIFO_AW'(push.n);
			rd_q    <= rd_q + FIFO_AW'(pop);
			count_q <= count_q + LEVEL_W'(push.n) - LEVEL_W'(pop);
		end
	end

	assign head              = mem[rd_q];
	assign level             = count_q;
	assign result.valid      = (count_q != '0);
	assign result.code_point = head.code_point;
	assign result.status     = head.status;
	assign result.last       = head.last;

endmodule

/* rtl/utf8_byte_stream_decoder_unit.sv */
// ----------------------------------------------------------------------------
// utf8_byte_stream_decoder_unit
// Lenient UTF-8 decoder: one text byte per transfer in, code point results out.
// ----------------------------------------------------------------------------
// Path: a byte is registered in the input stage, decoded, and its results go
//   to the result queue. Throughput: one byte per cycle while the queue has
//   room; a byte that yields two results (truncated sequence followed by
//   another result) pushes both into the single-pop four-entry result queue.
// Reset: arst_n clears the input stage, the open-sequence state and the queue.
// ----------------------------------------------------------------------------
module utf8_byte_stream_decoder_unit (
	input  logic          clk,
	input  logic          arst_n,
	ubsd_byte_if.sink     text,
	ubsd_result_if.source result
);
	import ubsd_pkg::*;

	// Input stage
	logic [BYTE_W-1:0]  byte_s1;
	logic               valid_s1;

	// Open-sequence state: gathered payload bits and trail bytes still due
	logic [CP_W-1:0]    partial_q;
	logic [TRAIL_W-1:0] trail_q;

	decode_t            dec;
	push_t              push;
	logic [LEVEL_W-1:0] level;
	logic [LEVEL_W:0]   fill_after;
	logic               advance;
	logic               take;

	ubsd_decode u_decode (
		.text_byte (byte_s1),
		.partial   (partial_q),
		.trail     (trail_q),
		.dec       (dec)
	);

	// Room check uses only registered level, so out.ready never reaches in.ready
	assign fill_after = {1'b0, level} + (LEVEL_W+1)'(dec.push.n);
	assign advance    = valid_s1 && (fill_after <= (LEVEL_W+1)'(FIFO_DEPTH));
	assign text.ready = !valid_s1 || advance;
	assign take       = text.valid && text.ready;

	always_comb begin
		push = dec.push;
		if (!advance) begin
			push.n = 2'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1 <= text.text_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			partial_q <= '0;
			trail_q   <= '0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				partial_q <= dec.next_partial;
				trail_q   <= dec.next_trail;
			end
		end
	end

	ubsd_result_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.level  (level),
		.result (result)
	);

endmodule
